// File: rtl/twgt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Twiddle gain tuner package
// Shared types, register addresses, fixed-point constants and the saturating
// helpers used by the tuner datapath.
// ----------------------------------------------------------------------------
package twgt_pkg;

    // Fixed-point format of gains and steps.
    localparam int FRACTION_BITS = 16;

    localparam int GAIN_W  = 32;
    localparam int STEP_W  = 32;
    localparam int COST_W  = 16;
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 3;

    // Step scale factors 1.1 and 0.9, rounded to nearest at FRACTION_BITS.
    localparam int K_W = FRACTION_BITS + 1;
    localparam logic [K_W-1:0] SCALE_UP   =
        K_W'(((64'd11 << FRACTION_BITS) + 64'd5) / 64'd10);
    localparam logic [K_W-1:0] SCALE_DOWN =
        K_W'(((64'd9 << FRACTION_BITS) + 64'd5) / 64'd10);

    // Register map.
    localparam logic [PADDR_W-1:0] ADDR_INITIAL_STEP   = 3'h0;
    localparam logic [PADDR_W-1:0] ADDR_STOP_THRESHOLD = 3'h4;

    localparam logic [STEP_W-1:0] INITIAL_STEP_RESET   = 32'h0001_0000;
    localparam logic [STEP_W-1:0] STOP_THRESHOLD_RESET = 32'h0000_0001;

    typedef logic signed [GAIN_W-1:0] gain_t;
    typedef logic [STEP_W-1:0]        step_t;
    typedef logic [COST_W-1:0]        cost_t;
    typedef logic [DATA_W-1:0]        data_t;
    typedef logic [PADDR_W-1:0]       paddr_t;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_PLUS,
        PH_MINUS
    } phase_t;

    // Base gain moved by the step in the direction of the phase, saturated
    // to the signed gain range. The first phase leaves the base alone.
    function automatic gain_t trial_gain(gain_t base, step_t step, phase_t ph);
        logic signed [GAIN_W+1:0] ext_base;
        logic signed [GAIN_W+1:0] ext_step;
        logic signed [GAIN_W+1:0] wide;
        gain_t                    result;
        ext_base = {{2{base[GAIN_W-1]}}, base};
        ext_step = {2'b00, step};
        unique case (ph)
            PH_PLUS:  wide = ext_base + ext_step;
            PH_MINUS: wide = ext_base - ext_step;
            default:  wide = ext_base;
        endcase
        if (wide[GAIN_W+1:GAIN_W-1] == 3'b000 || wide[GAIN_W+1:GAIN_W-1] == 3'b111) begin
            result = wide[GAIN_W-1:0];
        end
        else if (wide[GAIN_W+1]) begin
            result = {1'b1, {(GAIN_W-1){1'b0}}};
        end
        else begin
            result = {1'b0, {(GAIN_W-1){1'b1}}};
        end
        return result;
    endfunction

    // Step times a fixed-point factor, truncated, saturated to all ones.
    function automatic step_t scale_step(step_t step, logic [K_W-1:0] factor);
        logic [STEP_W+K_W-1:0] prod;
        step_t                 result;
        prod = {{K_W{1'b0}}, step} * {{STEP_W{1'b0}}, factor};
        if (|prod[STEP_W+K_W-1:STEP_W+FRACTION_BITS]) begin
            result = '1;
        end
        else begin
            result = prod[STEP_W+FRACTION_BITS-1:FRACTION_BITS];
        end
        return result;
    endfunction

endpackage

// File: rtl/twiddle_gain_tuner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Twiddle gain tuner
// Coordinate-descent search over controller gains in signed fixed point,
// driven by one measured cost per transaction.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Payload
//  -------   ---------  -------------------------  ------------------------------
//  cost      sink       cost_valid / cost_stall    measured_cost
//  result    source     result_valid/result_stall  trial_gain_p/i/d, best_cost,
//                                                  search_done
//  config    APB slave  psel/penable/pready        paddr, pwdata, prdata
//
//  Every cost transaction produces exactly one result transaction, available
//  the cycle after the cost is accepted. One cost is accepted per cycle while
//  cost_stall is low; the rate is set by the combinational state update (one
//  constant multiply for the step scale, one step-sum compare and one saturating add).
//  The cost channel stalls only while a result is waiting and result_stall
//  is high; a result taken in a cycle frees room for a new cost that cycle.
//  Reset (rst_n low, asynchronous) zeroes the gains, loads the steps with the
//  reset value of initial_step and sets the best cost to all ones.
//
module twiddle_gain_tuner #(
    parameter int NUM_GAINS = 3
) (
    input  logic               clk,
    input  logic               rst_n,

    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  twgt_pkg::paddr_t   paddr,
    input  twgt_pkg::data_t    pwdata,
    output twgt_pkg::data_t    prdata,
    output logic               pready,

    // Cost channel.
    input  logic               cost_valid,
    output logic               cost_stall,
    input  twgt_pkg::cost_t    measured_cost,

    // Result channel.
    output logic               result_valid,
    input  logic               result_stall,
    output twgt_pkg::gain_t    trial_gain_p,
    output twgt_pkg::gain_t    trial_gain_i,
    output twgt_pkg::gain_t    trial_gain_d,
    output twgt_pkg::cost_t    best_cost,
    output logic               search_done
);

    import twgt_pkg::*;

    localparam int COORD_W = (NUM_GAINS > 1) ? $clog2(NUM_GAINS) : 1;
    localparam int SUM_W   = STEP_W + $clog2(NUM_GAINS + 1);
    localparam int OUT_GAINS = 3;
    localparam logic [COORD_W-1:0] LAST_COORD = COORD_W'(NUM_GAINS - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    step_t initial_step_reg;
    step_t stop_threshold_reg;
    logic  cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_step_reg   <= INITIAL_STEP_RESET;
            stop_threshold_reg <= STOP_THRESHOLD_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr == ADDR_INITIAL_STEP)
            begin
                initial_step_reg <= pwdata;
            end
            if (paddr == ADDR_STOP_THRESHOLD)
            begin
                stop_threshold_reg <= pwdata;
            end
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_INITIAL_STEP:   prdata = initial_step_reg;
            ADDR_STOP_THRESHOLD: prdata = stop_threshold_reg;
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake. The search state itself is the result register: it only
    // changes when a cost is accepted, so a stalled result holds steady.
    // ------------------------------------------------------------------
    logic result_valid_reg;
    logic result_valid_next;
    logic cost_accept;

    assign cost_stall        = result_valid_reg && result_stall;
    assign cost_accept       = cost_valid && !cost_stall;
    assign result_valid_next = cost_accept || (result_valid_reg && result_stall);
    assign result_valid      = result_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Search state
    // ------------------------------------------------------------------
    gain_t               gains_reg [NUM_GAINS];
    gain_t               gains_next [NUM_GAINS];
    step_t               steps_reg [NUM_GAINS];
    step_t               steps_next [NUM_GAINS];
    cost_t               lowest_cost_reg;
    cost_t               lowest_cost_next;
    logic [COORD_W-1:0]  coordinate_reg;
    logic [COORD_W-1:0]  coordinate_next;
    phase_t              phase_reg;
    phase_t              phase_next;
    logic                finished_reg;
    logic                finished_next;

    // Values for the coordinate under trial.
    gain_t               cur_trial;
    step_t               cur_scaled;
    logic                improved;

    assign improved   = measured_cost < lowest_cost_reg;
    assign cur_trial  = trial_gain(gains_reg[coordinate_reg], steps_reg[coordinate_reg],
                                   phase_reg);
    // One multiplier serves both the grow and the shrink of the step.
    assign cur_scaled = scale_step(steps_reg[coordinate_reg],
                                   improved ? SCALE_UP : SCALE_DOWN);

    always_comb
    begin
        logic [SUM_W-1:0] step_sum;
        logic             round_end;

        gains_next       = gains_reg;
        steps_next       = steps_reg;
        lowest_cost_next = lowest_cost_reg;
        coordinate_next  = coordinate_reg;
        phase_next       = phase_reg;
        finished_next    = finished_reg;
        round_end        = 1'b0;

        if (cost_accept && !finished_reg)
        begin
            priority if (phase_reg == PH_FIRST)
            begin
                // The first measurement sets the baseline and reloads the steps.
                lowest_cost_next = measured_cost;
                for (int i = 0; i < NUM_GAINS; i++)
                begin
                    steps_next[i] = initial_step_reg;
                end
                round_end = 1'b1;
            end
            else if (improved)
            begin
                // Keep the trial value as the new base and grow the step.
                lowest_cost_next           = measured_cost;
                gains_next[coordinate_reg] = cur_trial;
                steps_next[coordinate_reg] = cur_scaled;
                round_end                  = (coordinate_reg == LAST_COORD);
                coordinate_next            = coordinate_reg + 1'b1;
                phase_next                 = PH_PLUS;
            end
            else if (phase_reg == PH_PLUS)
            begin
                phase_next = PH_MINUS;
            end
            else
            begin
                // Both directions failed: the base stays, the step shrinks.
                steps_next[coordinate_reg] = cur_scaled;
                round_end                  = (coordinate_reg == LAST_COORD);
                coordinate_next            = coordinate_reg + 1'b1;
                phase_next                 = PH_PLUS;
            end
        end

        step_sum = '0;
        for (int i = 0; i < NUM_GAINS; i++)
        begin
            step_sum = step_sum + SUM_W'(steps_next[i]);
        end

        if (round_end)
        begin
            coordinate_next = '0;
            if (step_sum <= SUM_W'(stop_threshold_reg))
            begin
                finished_next = 1'b1;
                phase_next    = PH_FIRST;
            end
            else
            begin
                phase_next = PH_PLUS;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_GAINS; i++)
            begin
                gains_reg[i] <= '0;
                steps_reg[i] <= INITIAL_STEP_RESET;
            end
            lowest_cost_reg <= '1;
            coordinate_reg  <= '0;
            phase_reg       <= PH_FIRST;
            finished_reg    <= 1'b0;
        end
        else
        begin
            gains_reg       <= gains_next;
            steps_reg       <= steps_next;
            lowest_cost_reg <= lowest_cost_next;
            coordinate_reg  <= coordinate_next;
            phase_reg       <= phase_next;
            finished_reg    <= finished_next;
        end
    end

    // ------------------------------------------------------------------
    // Result fields. Only the coordinate under trial is offset by its step;
    // a gain slot with no gain behind it reads as zero.
    // ------------------------------------------------------------------
    gain_t gain_slot [OUT_GAINS];

    for (genvar k = 0; k < OUT_GAINS; k++)
    begin : g_slot
        if (k < NUM_GAINS)
        begin : g_used
            assign gain_slot[k] = (finished_reg || coordinate_reg != COORD_W'(k))
                                ? gains_reg[k]
                                : trial_gain(gains_reg[k], steps_reg[k], phase_reg);
        end
        else
        begin : g_unused
            assign gain_slot[k] = '0;
        end
    end

    assign trial_gain_p = gain_slot[0];
    assign trial_gain_i = gain_slot[1];
    assign trial_gain_d = gain_slot[2];
    assign best_cost    = lowest_cost_reg;
    assign search_done  = finished_reg;

endmodule
